@@ rtl/c8frcr_pkg.sv @@
// Shared types, byte codes and the CRC-8 step function for the framed relay
// command receiver. No dependencies.
package c8frcr_pkg;

    localparam int          MAX_PAYLOAD_LEN     = 64;
    localparam int          JOB_QUEUE_DEPTH     = 2;
    localparam logic [15:0] IDLE_TIMEOUT_RESET  = 16'd1475;

    localparam logic [7:0] PREAMBLE     = 8'h40;
    localparam logic [7:0] TRAILER      = 8'haa;
    localparam logic [7:0] TIMEOUT_MARK = 8'h66;   // ASCII 'f'
    localparam logic [7:0] NODE_ID_RST  = 8'haa;
    localparam logic [7:0] ACK_LEN      = 8'd1;
    localparam logic [7:0] CMD_ON       = 8'h81;
    localparam logic [7:0] CMD_OFF      = 8'h82;
    localparam logic [7:0] CMD_SETID    = 8'h83;
    localparam logic [7:0] CMD_INVERT   = 8'h84;
    localparam logic [7:0] CRC_POLY     = 8'h8c;   // 0x31 reflected

    localparam logic [2:0] ACK_LAST_IDX = 3'd5;

    // One reply for the back end: a timeout marker or a full acknowledge frame.
    typedef struct packed {
        logic       is_timeout;
        logic [7:0] node_id;
        logic [7:0] sender;
        logic       status;
        logic       relay;
        logic       invert;
        logic       save_id;
        logic       save_invert;
    } t_job;

    // Reflected CRC-8 over one byte, bit-serial form unrolled over eight steps.
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

@@ rtl/c8frcr_front.sv @@
// Front end: frame parser, idle timer and command execution.
// Depends on c8frcr_pkg; pushes one t_job per reply into the job queue.
module c8frcr_front
    import c8frcr_pkg::*;
#(
    parameter int P_MAX_PAYLOAD_LEN = MAX_PAYLOAD_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_accept,
    input  logic        i_tick,
    input  logic [7:0]  i_byte,
    output logic        o_push,
    output t_job        o_job
);

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_SRC   = 6'b000010,
        PH_DST   = 6'b000100,
        PH_LEN   = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_CHECK = 6'b100000
    } t_phase;

    localparam logic [7:0] MaxLen = 8'(P_MAX_PAYLOAD_LEN);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_sender, n_sender;
    logic [7:0]  r_target, n_target;
    logic [6:0]  r_len, n_len;
    logic [6:0]  r_taken, n_taken;
    logic [7:0]  r_cmd [2];
    logic [7:0]  r_node_id, n_node_id;
    logic        r_invert, n_invert;
    logic        r_relay, n_relay;
    logic        r_armed, n_armed;
    logic [15:0] r_idle, n_idle;
    logic [15:0] r_timeout;

    logic [15:0] idle_inc;
    logic [7:0]  crc_next;
    logic [6:0]  taken_inc;
    logic        cmd_we;
    logic        status;
    logic        sid, sinv;
    logic        push_ack, push_to;

    assign idle_inc  = r_idle + 16'd1;
    assign crc_next  = crc8_fold(r_crc, i_byte);
    assign taken_inc = r_taken + 7'd1;

    always_comb begin
        n_phase   = r_phase;
        n_crc     = r_crc;
        n_sender  = r_sender;
        n_target  = r_target;
        n_len     = r_len;
        n_taken   = r_taken;
        n_node_id = r_node_id;
        n_invert  = r_invert;
        n_relay   = r_relay;
        n_armed   = r_armed;
        n_idle    = r_idle;
        cmd_we    = 1'b0;
        status    = 1'b1;
        sid       = 1'b0;
        sinv      = 1'b0;
        push_ack  = 1'b0;
        push_to   = 1'b0;
        if (i_accept && i_tick) begin
            if (r_armed) begin
                if (idle_inc < r_timeout) begin
                    n_idle = idle_inc;
                end else begin
                    n_phase = PH_IDLE;
                    n_crc   = 8'd0;
                    n_taken = 7'd0;
                    n_armed = 1'b0;
                    n_idle  = 16'd0;
                    push_to = 1'b1;
                end
            end
        end else if (i_accept) begin
            n_armed = 1'b1;
            n_idle  = 16'd0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_byte == PREAMBLE) begin
                        n_crc   = crc_next;
                        n_phase = PH_SRC;
                    end
                end
                PH_SRC: begin
                    n_crc    = crc_next;
                    n_sender = i_byte;
                    n_phase  = PH_DST;
                end
                PH_DST: begin
                    n_crc    = crc_next;
                    n_target = i_byte;
                    n_phase  = PH_LEN;
                end
                PH_LEN: begin
                    if (i_byte > MaxLen) begin
                        n_phase = PH_IDLE;
                        n_crc   = 8'd0;
                        n_taken = 7'd0;
                    end else begin
                        n_crc   = crc_next;
                        n_len   = i_byte[6:0];
                        n_taken = 7'd0;
                        n_phase = (i_byte == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_crc   = crc_next;
                    cmd_we  = (r_taken < 7'd2);
                    n_taken = taken_inc;
                    if (taken_inc >= r_len) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_armed = 1'b0;
                    n_phase = PH_IDLE;
                    n_crc   = 8'd0;
                    n_taken = 7'd0;
                    if ((r_crc == i_byte) && (r_target == r_node_id)) begin
                        push_ack = 1'b1;
                        if (r_len == 7'd2 && r_cmd[0] == CMD_INVERT) begin
                            n_invert = (r_cmd[1] != 8'd0);
                            sinv     = (n_invert != r_invert);
                            status   = 1'b0;
                        end else if (r_len == 7'd2 && r_cmd[0] == CMD_SETID) begin
                            n_node_id = r_cmd[1];
                            sid       = (r_cmd[1] != r_node_id);
                            status    = 1'b0;
                        end else if (r_len == 7'd1 && r_cmd[0] == CMD_OFF) begin
                            n_relay = r_invert;
                            status  = 1'b0;
                        end else if (r_len == 7'd1 && r_cmd[0] == CMD_ON) begin
                            n_relay = ~r_invert;
                            status  = 1'b0;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_crc   = 8'd0;
                    n_taken = 7'd0;
                end
            endcase
        end
    end

    assign o_push             = push_ack | push_to;
    assign o_job.is_timeout   = push_to;
    assign o_job.node_id      = n_node_id;
    assign o_job.sender       = r_sender;
    assign o_job.status       = status;
    assign o_job.relay        = n_relay;
    assign o_job.invert       = n_invert;
    assign o_job.save_id      = sid;
    assign o_job.save_invert  = sinv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_crc     <= 8'd0;
            r_sender  <= 8'd0;
            r_target  <= 8'd0;
            r_len     <= 7'd0;
            r_taken   <= 7'd0;
            r_node_id <= NODE_ID_RST;
            r_invert  <= 1'b0;
            r_relay   <= 1'b0;
            r_armed   <= 1'b0;
            r_idle    <= 16'd0;
            r_timeout <= IDLE_TIMEOUT_RESET;
        end else begin
            r_phase   <= n_phase;
            r_crc     <= n_crc;
            r_sender  <= n_sender;
            r_target  <= n_target;
            r_len     <= n_len;
            r_taken   <= n_taken;
            r_node_id <= n_node_id;
            r_invert  <= n_invert;
            r_relay   <= n_relay;
            r_armed   <= n_armed;
            r_idle    <= n_idle;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    // Command bytes carry no reset; they are read only after being written.
    always_ff @(posedge i_clk) begin
        if (cmd_we) begin
            r_cmd[r_taken[0]] <= i_byte;
        end
    end

    a_check_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_tick && r_phase == PH_CHECK) |=> (!r_armed && r_phase == PH_IDLE))
        else $error("check byte did not disarm the timer and reset the parser");

endmodule

@@ rtl/c8frcr_queue.sv @@
// Small job queue in flip-flops between the front and back ends.
// Depends on c8frcr_pkg for t_job.
module c8frcr_queue
    import c8frcr_pkg::*;
#(
    parameter int P_DEPTH = JOB_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    localparam int PtrW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CntW = $clog2(P_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(P_DEPTH - 1);
    localparam logic [CntW-1:0] DepthCnt = CntW'(P_DEPTH);

    t_job            r_mem [P_DEPTH];
    logic [PtrW-1:0] r_wptr, r_rptr;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == DepthCnt);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LastPtr) ? '0 : r_wptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LastPtr) ? '0 : r_rptr + PtrW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CntW'(1);
                2'b01:   r_count <= r_count - CntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DepthCnt)
        else $error("queue count beyond depth");

endmodule

@@ rtl/c8frcr_back.sv @@
// Back end: serializes queued jobs into transmit bytes on the output stream.
// Depends on c8frcr_pkg for t_job and byte codes.
module c8frcr_back
    import c8frcr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_q_job,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic [3:0] o_user
);

    logic       r_valid;
    logic [2:0] r_idx;
    t_job       r_job;
    logic       take;
    logic       xfer;

    assign o_valid = r_valid;
    assign o_last  = r_job.is_timeout | (r_idx == ACK_LAST_IDX);
    assign o_user  = {r_job.save_invert, r_job.save_id, r_job.invert, r_job.relay};
    assign xfer    = r_valid & i_ready;
    assign take    = ~r_valid | (xfer & o_last);
    assign o_q_pop = take & i_q_valid;

    always_comb begin
        if (r_job.is_timeout) begin
            o_byte = TIMEOUT_MARK;
        end else begin
            unique case (r_idx)
                3'd0:    o_byte = PREAMBLE;
                3'd1:    o_byte = r_job.node_id;
                3'd2:    o_byte = r_job.sender;
                3'd3:    o_byte = ACK_LEN;
                3'd4:    o_byte = {7'd0, r_job.status};
                default: o_byte = TRAILER;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (take) begin
            r_valid <= i_q_valid;
            r_idx   <= 3'd0;
        end else if (xfer) begin
            r_idx   <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_q_job;
        end
    end

endmodule

@@ rtl/crc8_framed_relay_command_receiver_unit.sv @@
// Path: the reply to an input transaction is written into the job queue at the edge that accepts
//   the input and is then loaded into the output register, when the job queue and the output are idle.
// Throughput: one input transaction per cycle while the two-entry job queue has room;
//   an acknowledge is six output bytes and a timeout marker one byte,
//   so the output serializer and the sink's ready set the sustained rate.
// Reset: synchronous, active low; clears parser, timer, flags and queue and sets node id to 0xaa at once.
// Top level of the framed relay command receiver; depends on c8frcr_pkg and the
// front, queue and back submodules.
module crc8_framed_relay_command_receiver_unit
    import c8frcr_pkg::*;
#(
    parameter int P_MAX_PAYLOAD_LEN = MAX_PAYLOAD_LEN,
    parameter int P_QUEUE_DEPTH     = JOB_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: idle timeout in ticks
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] operation (0 byte, 1 tick)
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    output logic        m_axis_tlast,   // last byte of this input's run
    output logic [3:0]  m_axis_tuser    // [0] relay_level [1] invert_flag
                                        // [2] save_id [3] save_invert
);

    logic q_full;
    logic q_valid;
    logic q_pop;
    logic push;
    logic accept;
    t_job push_job;
    t_job head_job;

    // Accept inputs whenever the queue can absorb a reply; the front end may
    // produce at most one job per transaction.
    assign s_axis_tready = ~q_full;
    assign accept        = s_axis_tvalid & s_axis_tready;

    // Parse bytes, run the idle timer and execute commands.
    c8frcr_front #(
        .P_MAX_PAYLOAD_LEN(P_MAX_PAYLOAD_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_accept   (accept),
        .i_tick     (s_axis_tuser),
        .i_byte     (s_axis_tdata),
        .o_push     (push),
        .o_job      (push_job)
    );

    // Decouple parsing from transmission so each side can stall alone.
    c8frcr_queue #(
        .P_DEPTH(P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_job  (head_job)
    );

    // Emit the reply bytes, holding each until the sink takes it.
    c8frcr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_job  (head_job),
        .o_q_pop  (q_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_byte   (m_axis_tdata),
        .o_last   (m_axis_tlast),
        .o_user   (m_axis_tuser)
    );

endmodule
